// File: rtl/combined_lcg_random_assert.svh
// Assertion macros shared by the combined generator RTL.
`ifndef COMBINED_LCG_RANDOM_ASSERT_SVH
`define COMBINED_LCG_RANDOM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/clr_pkg.sv
// Package with constants and types of the combined generator.
package clr_pkg;

  localparam int VAL_W  = 31;
  localparam int MULT_W = 16;
  localparam int FOLD_W = 8;
  localparam int PROD_W = VAL_W + MULT_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [MULT_W-1:0] MULT_ONE = 16'd40014;
  localparam logic [MULT_W-1:0] MULT_TWO = 16'd40692;
  // Each modulus is 2^31 minus a small fold constant.
  localparam logic [FOLD_W-1:0] FOLD_ONE = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD_TWO = 8'd249;
  localparam logic [VAL_W-1:0]  MOD_ONE  = 31'h7FFFFFAB;
  localparam logic [VAL_W-1:0]  MOD_TWO  = 31'h7FFFFF07;
  localparam logic [VAL_W-1:0]  WRAP_ADD = 31'h7FFFFFAA;

  localparam logic [VAL_W-1:0]  SEED_ONE_RST = 31'd12345;
  localparam logic [VAL_W-1:0]  SEED_TWO_RST = 31'd67890;
  localparam logic [VAL_W-1:0]  SEED_ONE_TOP = 31'h7FFFFFAA;
  localparam logic [VAL_W-1:0]  SEED_TWO_TOP = 31'h7FFFFF06;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_TWO = 2'd1;

  localparam logic GEN_ONE = 1'b0;
  localparam logic GEN_TWO = 1'b1;

  // One operation for, or one result from, the shared modular multiplier.
  typedef struct packed {
    logic             valid;
    logic             gen;
    logic [VAL_W-1:0] value;
  } clr_op_t;

endpackage

// File: rtl/clr_if.sv
// Handshake interfaces for the request and result channels.
interface clr_req_if import clr_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface clr_rsp_if import clr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] random_value;
  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

// File: rtl/clr_seed_regs.sv
// Seed registers with saturation into each generator's valid range.
module clr_seed_regs import clr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  output logic [VAL_W-1:0]     seed_one,
  output logic [VAL_W-1:0]     seed_two
);

  function automatic logic [VAL_W-1:0] clamp_seed(input logic [VAL_W-1:0] v,
                                                  input logic [VAL_W-1:0] top);
    logic [VAL_W-1:0] r;
    if (v == '0) begin
      r = {{(VAL_W-1){1'b0}}, 1'b1};
    end else if (v > top) begin
      r = top;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_one <= SEED_ONE_RST;
      seed_two <= SEED_TWO_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SEED_ONE: seed_one <= clamp_seed(cfg_data, SEED_ONE_TOP);
        CFG_SEED_TWO: seed_two <= clamp_seed(cfg_data, SEED_TWO_TOP);
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/clr_mulmod.sv
// Shared unit: residue times multiplier, folded modulo 2^31 minus a constant.
module clr_mulmod import clr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  clr_op_t op,
  output clr_op_t res
);

  logic [MULT_W-1:0] mult;
  logic [PROD_W-1:0] prod_c;
  logic [PROD_W-1:0] prod;
  logic              prod_valid;
  logic              prod_gen;

  logic [FOLD_W-1:0]       fold_b;
  logic [FOLD_W+MULT_W-1:0] hi_c;
  logic [VAL_W:0]          fold1;
  logic                    fold1_valid;
  logic                    fold1_gen;

  logic [FOLD_W-1:0] fold_c;
  logic [VAL_W-1:0]  mod_c;
  logic [VAL_W:0]    fold2;
  logic [VAL_W:0]    fold2_sub;

  assign mult   = (op.gen == GEN_TWO) ? MULT_TWO : MULT_ONE;
  assign prod_c = {{MULT_W{1'b0}}, op.value} * {{VAL_W{1'b0}}, mult};

  // First fold: the bits above 2^31 come back in times the fold constant.
  assign fold_b = (prod_gen == GEN_TWO) ? FOLD_TWO : FOLD_ONE;
  assign hi_c   = {{FOLD_W{1'b0}}, prod[PROD_W-1:VAL_W]} * {{MULT_W{1'b0}}, fold_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid  <= 1'b0;
      fold1_valid <= 1'b0;
    end else begin
      prod_valid  <= op.valid;
      fold1_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= prod_c;
    prod_gen  <= op.gen;
    fold1     <= {1'b0, prod[VAL_W-1:0]} + {{(VAL_W+1-FOLD_W-MULT_W){1'b0}}, hi_c};
    fold1_gen <= prod_gen;
  end

  // Second fold leaves a value below twice the modulus; one subtract finishes.
  assign fold_c    = (fold1_gen == GEN_TWO) ? FOLD_TWO : FOLD_ONE;
  assign mod_c     = (fold1_gen == GEN_TWO) ? MOD_TWO : MOD_ONE;
  assign fold2     = {1'b0, fold1[VAL_W-1:0]}
                   + (fold1[VAL_W] ? {{(VAL_W+1-FOLD_W){1'b0}}, fold_c} : '0);
  assign fold2_sub = fold2 - {1'b0, mod_c};

  assign res.valid = fold1_valid;
  assign res.gen   = fold1_gen;
  assign res.value = (fold2 >= {1'b0, mod_c}) ? fold2_sub[VAL_W-1:0] : fold2[VAL_W-1:0];

endmodule

// File: rtl/combined_lcg_random.sv
// Combined multiplicative congruential generator, top level.
//
// Each request transaction on req carries a restart flag and produces one
// result transaction on rsp with a 31-bit value in 1..2147483562. With
// restart high both residues are reloaded from the seed registers before
// the step; otherwise the generator continues from its current residues.
// The user must write the seeds through cfg_write, cfg_index and cfg_data
// only while the block is idle; the block does not enforce this. Index 0 is
// the first seed, index 1 the second, others are ignored, and out-of-range
// values saturate into the valid range. One shared multiply-and-fold unit
// (two register stages) serves both generators in turn, so a request is
// taken only in ST_IDLE; a step runs through ST_ONE, ST_TWO, ST_WAIT and
// ST_DONE, and req.ready returns as the result enters the output register.
// While the receiver stalls, the next request may already be accepted and
// computed, and it then waits for the register to empty. Reset restores the
// seeds and residues to 12345 and 67890 and empties the output register.
module combined_lcg_random import clr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  clr_req_if.sink              req,
  clr_rsp_if.source            rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

`include "combined_lcg_random_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ONE  = 3'd1;
  localparam logic [2:0] ST_TWO  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       st;
  logic [2:0]       st_next;
  logic [VAL_W-1:0] seed_one;
  logic [VAL_W-1:0] seed_two;
  logic [VAL_W-1:0] state_one;
  logic [VAL_W-1:0] state_two;
  logic [VAL_W-1:0] out_value;
  logic             out_valid;
  logic [VAL_W-1:0] diff;
  logic             req_fire;
  logic             out_load;
  clr_op_t          op;
  clr_op_t          res;

  clr_seed_regs u_seed (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seed_one  (seed_one),
    .seed_two  (seed_two)
  );

  clr_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .res (res)
  );

  assign req.ready = (st == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_load  = (st == ST_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    op.valid = (st == ST_ONE) || (st == ST_TWO);
    op.gen   = (st == ST_TWO) ? GEN_TWO : GEN_ONE;
    op.value = (st == ST_TWO) ? state_two : state_one;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (req_fire) st_next = ST_ONE;
      ST_ONE:  st_next = ST_TWO;
      ST_TWO:  st_next = ST_WAIT;
      ST_WAIT: if (res.valid && res.gen == GEN_TWO) st_next = ST_DONE;
      ST_DONE: if (out_load) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_one <= SEED_ONE_RST;
      state_two <= SEED_TWO_RST;
    end else if (req_fire && req.restart) begin
      state_one <= seed_one;
      state_two <= seed_two;
    end else if (res.valid) begin
      if (res.gen == GEN_TWO) begin
        state_two <= res.value;
      end else begin
        state_one <= res.value;
      end
    end
  end

  // Equal residues wrap to the top value.
  assign diff = (state_one > state_two) ? (state_one - state_two)
                                        : (WRAP_ADD - (state_two - state_one));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= diff;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_value;

  `CLR_ASSERT_SAME(a_out_range, out_valid,
    (out_value != '0) && (out_value <= WRAP_ADD), "result out of range")
  `CLR_ASSERT_SAME(a_state_range, 1'b1,
    (state_one != '0) && (state_one < MOD_ONE) && (state_two != '0) && (state_two < MOD_TWO),
    "generator residue out of range")
  `CLR_ASSERT_SAME(a_res_busy, res.valid,
    (st == ST_WAIT) || (st == ST_TWO), "multiplier result outside of a step")
  `CLR_ASSERT_NEXT(a_load_valid, out_load, out_valid && (st == ST_IDLE),
    "result register not filled after a step")

endmodule
